FILE: rtl/acd_pkg.sv
// Shared types and constants for the accelerometer shake detector.
// Used by acd_front, acd_fifo, acd_back and accel_shake_detector. No dependencies.
`default_nettype none

package acd_pkg;

  // Input item kinds
  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_POLL   = 1'b1
  } kind_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_JOLT_THRESHOLD = 3'd0,
    REG_JOLTS_NEEDED   = 3'd1,
    REG_WINDOW         = 3'd2,
    REG_COOLDOWN       = 3'd3,
    REG_GRAVITY        = 3'd4,
    REG_WAKE_DEVIATION = 3'd5
  } cfg_idx_t;

  localparam int unsigned MG_W      = 14;  // milli-g register width
  localparam int unsigned ACC_W     = 14;  // signed axis width
  localparam int unsigned MS_W      = 16;  // window / cooldown width
  localparam int unsigned CNT_W     = 4;   // jolt count width
  localparam int unsigned TS_W      = 32;  // timestamp width
  localparam int unsigned CFG_W     = 16;  // config write data width
  localparam int unsigned SQ_W      = 27;  // one axis squared
  localparam int unsigned M2_W      = 28;  // sum of three squares
  localparam int unsigned HI_W      = 15;  // gravity + deviation
  localparam int unsigned HI2_W     = 30;  // (gravity + deviation) squared
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = 1;

  // Reset values of the registers and state
  localparam logic [MG_W-1:0]  RST_JOLT_THRESHOLD = 14'd1800;
  localparam logic [CNT_W-1:0] RST_JOLTS_NEEDED   = 4'd3;
  localparam logic [MS_W-1:0]  RST_WINDOW         = 16'd800;
  localparam logic [MS_W-1:0]  RST_COOLDOWN       = 16'd1500;
  localparam logic [MG_W-1:0]  RST_GRAVITY        = 14'd1000;
  localparam logic [MG_W-1:0]  RST_WAKE_DEVIATION = 14'd450;
  localparam logic [TS_W-1:0]  RST_COOLDOWN_END   = 32'd1500;
  localparam logic [CNT_W-1:0] CNT_MAX            = 4'd15;

  // Configuration register file contents
  typedef struct packed {
    logic [MG_W-1:0]  jolt_threshold_mg;
    logic [CNT_W-1:0] jolts_needed;
    logic [MS_W-1:0]  window_ms;
    logic [MS_W-1:0]  cooldown_ms;
    logic [MG_W-1:0]  gravity_mg;
    logic [MG_W-1:0]  wake_deviation_mg;
  } cfg_t;

  // Classified request handed from front to back
  typedef struct packed {
    kind_t           kind;
    logic            jolt_mag;   // magnitude above jolt threshold
    logic            moved_hit;  // magnitude outside gravity band
    logic [TS_W-1:0] now_ms;
  } cls_t;

endpackage

`default_nettype wire

FILE: rtl/accel_shake_detector.sv
// Top level of the accelerometer shake detector: config registers and the
// front / queue / back chain. Depends on acd_pkg, acd_front, acd_fifo, acd_back.
`default_nettype none

// One request enters per cycle while in_ready is high. Its squares are
// registered when it is accepted; the sum and compare are then written into a
// two-entry queue, and the back end pops the entry and writes its state update
// into the result register. Throughput is one request per cycle while results
// are taken, set by the back end, which updates the jolt count, window and
// cooldown state once per request. Squared thresholds are registered in the
// cycle after a config write. Each request gives exactly one result: shake on
// samples, the moved flag (then cleared) on polls.
module accel_shake_detector (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [2:0]                        cfg_index,
  input  wire logic [acd_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              kind,
  input  wire logic signed [acd_pkg::ACC_W-1:0]  accel_x,
  input  wire logic signed [acd_pkg::ACC_W-1:0]  accel_y,
  input  wire logic signed [acd_pkg::ACC_W-1:0]  accel_z,
  input  wire logic [acd_pkg::TS_W-1:0]          now_ms,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   shake,
  output logic                                   moved
);

  // configuration registers; unknown indexes are ignored
  acd_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.jolt_threshold_mg <= acd_pkg::RST_JOLT_THRESHOLD;
      cfg.jolts_needed      <= acd_pkg::RST_JOLTS_NEEDED;
      cfg.window_ms         <= acd_pkg::RST_WINDOW;
      cfg.cooldown_ms       <= acd_pkg::RST_COOLDOWN;
      cfg.gravity_mg        <= acd_pkg::RST_GRAVITY;
      cfg.wake_deviation_mg <= acd_pkg::RST_WAKE_DEVIATION;
    end else if (cfg_wr_en) begin
      case (acd_pkg::cfg_idx_t'(cfg_index))
        acd_pkg::REG_JOLT_THRESHOLD: cfg.jolt_threshold_mg <= cfg_data[acd_pkg::MG_W-1:0];
        acd_pkg::REG_JOLTS_NEEDED:   cfg.jolts_needed      <= cfg_data[acd_pkg::CNT_W-1:0];
        acd_pkg::REG_WINDOW:         cfg.window_ms         <= cfg_data;
        acd_pkg::REG_COOLDOWN:       cfg.cooldown_ms       <= cfg_data;
        acd_pkg::REG_GRAVITY:        cfg.gravity_mg        <= cfg_data[acd_pkg::MG_W-1:0];
        acd_pkg::REG_WAKE_DEVIATION: cfg.wake_deviation_mg <= cfg_data[acd_pkg::MG_W-1:0];
        default: begin
          cfg.jolts_needed <= cfg.jolts_needed;
        end
      endcase
    end
  end

  logic          push;
  logic          full;
  logic          pop;
  logic          nonempty;
  acd_pkg::cls_t push_data;
  acd_pkg::cls_t pop_data;

  acd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .accel_x   (accel_x),
    .accel_y   (accel_y),
    .accel_z   (accel_z),
    .now_ms    (now_ms),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  acd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .nonempty  (nonempty)
  );

  acd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .nonempty  (nonempty),
    .req       (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .shake     (shake),
    .moved     (moved)
  );

endmodule

`default_nettype wire

FILE: rtl/acd_front.sv
// Front end: accepts requests, squares the axes and classifies the magnitude.
// Depends on acd_pkg. Squared thresholds are kept in registers from the config.
`default_nettype none

module acd_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire acd_pkg::cfg_t                 cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          kind,
  input  wire logic signed [acd_pkg::ACC_W-1:0] accel_x,
  input  wire logic signed [acd_pkg::ACC_W-1:0] accel_y,
  input  wire logic signed [acd_pkg::ACC_W-1:0] accel_z,
  input  wire logic [acd_pkg::TS_W-1:0]      now_ms,
  output logic                               push,
  output acd_pkg::cls_t                      push_data,
  input  wire logic                          full
);

  // squared thresholds
  logic [acd_pkg::M2_W-1:0]  th2;
  logic [acd_pkg::HI2_W-1:0] hi2;
  logic [acd_pkg::M2_W-1:0]  lo2;
  logic                      lo_en;
  logic [acd_pkg::HI_W-1:0]  hi_sum;
  logic [acd_pkg::MG_W-1:0]  lo_diff;

  assign hi_sum  = {1'b0, cfg.gravity_mg} + {1'b0, cfg.wake_deviation_mg};
  assign lo_diff = cfg.gravity_mg - cfg.wake_deviation_mg;

  always_ff @(posedge clk) begin
    th2   <= acd_pkg::M2_W'(cfg.jolt_threshold_mg) * acd_pkg::M2_W'(cfg.jolt_threshold_mg);
    hi2   <= acd_pkg::HI2_W'(hi_sum) * acd_pkg::HI2_W'(hi_sum);
    lo2   <= acd_pkg::M2_W'(lo_diff) * acd_pkg::M2_W'(lo_diff);
    lo_en <= cfg.gravity_mg > cfg.wake_deviation_mg;
  end

  // stage 1: per-axis squares
  logic                      s1_valid;
  acd_pkg::kind_t            s1_kind;
  logic [acd_pkg::TS_W-1:0]  s1_now;
  logic [acd_pkg::SQ_W-1:0]  sq_x, sq_y, sq_z;
  logic                      s1_adv;

  // full-width signed products
  logic signed [2*acd_pkg::ACC_W-1:0] p_x, p_y, p_z;

  assign p_x = (2*acd_pkg::ACC_W)'(accel_x) * (2*acd_pkg::ACC_W)'(accel_x);
  assign p_y = (2*acd_pkg::ACC_W)'(accel_y) * (2*acd_pkg::ACC_W)'(accel_y);
  assign p_z = (2*acd_pkg::ACC_W)'(accel_z) * (2*acd_pkg::ACC_W)'(accel_z);

  assign s1_adv   = s1_valid && !full;
  assign in_ready = !s1_valid || !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind <= acd_pkg::kind_t'(kind);
      s1_now  <= now_ms;
      sq_x    <= p_x[acd_pkg::SQ_W-1:0];
      sq_y    <= p_y[acd_pkg::SQ_W-1:0];
      sq_z    <= p_z[acd_pkg::SQ_W-1:0];
    end
  end

  // sum and compare into the queue
  logic [acd_pkg::M2_W-1:0] m2;

  assign m2 = {1'b0, sq_x} + {1'b0, sq_y} + {1'b0, sq_z};

  always_comb begin
    push                = s1_adv;
    push_data.kind      = s1_kind;
    push_data.now_ms    = s1_now;
    push_data.jolt_mag  = m2 > th2;
    push_data.moved_hit = ({2'b00, m2} > hi2) || (lo_en && (m2 < lo2));
  end

endmodule

`default_nettype wire

FILE: rtl/acd_fifo.sv
// Two-entry queue of classified requests between front and back.
// Depends on acd_pkg.
`default_nettype none

module acd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire acd_pkg::cls_t push_data,
  output logic               full,
  input  wire logic          pop,
  output acd_pkg::cls_t      pop_data,
  output logic               nonempty
);

  acd_pkg::cls_t                 mem [acd_pkg::FIFO_DEPTH];
  logic [acd_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [acd_pkg::FIFO_AW-1:0]   rd_ptr;
  logic [acd_pkg::FIFO_AW:0]     count;

  assign full     = count == (acd_pkg::FIFO_AW+1)'(acd_pkg::FIFO_DEPTH);
  assign nonempty = count != '0;
  assign pop_data = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/acd_back.sv
// Back end: jolt counting, window and cooldown timing, moved flag, result register.
// Depends on acd_pkg. Pops one queued request per cycle while no result is stalled.
`default_nettype none

module acd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire acd_pkg::cfg_t cfg,
  input  wire logic          nonempty,
  input  wire acd_pkg::cls_t req,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               shake,
  output logic               moved
);

  // detector state
  logic [acd_pkg::CNT_W-1:0] jolt_count, jolt_count_next;
  logic [acd_pkg::TS_W-1:0]  window_begin, window_begin_next;
  logic [acd_pkg::TS_W-1:0]  cooldown_end, cooldown_end_next;
  logic                      moved_flag, moved_flag_next;
  logic                      shake_next, moved_next;

  assign pop = nonempty && (!out_valid || out_ready);

  logic [acd_pkg::TS_W-1:0]  d_cool;
  logic [acd_pkg::TS_W-1:0]  d_win;
  logic [acd_pkg::CNT_W-1:0] cnt_inc;
  logic                      jolt, new_window, win_open, win_over;

  always_comb begin
    d_cool     = req.now_ms - cooldown_end;
    jolt       = (req.kind == acd_pkg::KIND_SAMPLE) && req.jolt_mag &&
                 !d_cool[acd_pkg::TS_W-1] && (d_cool != '0);
    new_window = jolt && (jolt_count == '0);
    // a fresh window starts at this sample, so its distance is zero
    d_win      = new_window ? '0 : (req.now_ms - window_begin);
    win_open   = d_win[acd_pkg::TS_W-1] ||
                 (d_win < {{(acd_pkg::TS_W-acd_pkg::MS_W){1'b0}}, cfg.window_ms});
    win_over   = !d_win[acd_pkg::TS_W-1] &&
                 (d_win > {{(acd_pkg::TS_W-acd_pkg::MS_W){1'b0}}, cfg.window_ms});
    cnt_inc    = (jolt_count == acd_pkg::CNT_MAX) ? jolt_count : jolt_count + 1'b1;

    jolt_count_next   = jolt_count;
    window_begin_next = new_window ? req.now_ms : window_begin;
    cooldown_end_next = cooldown_end;
    moved_flag_next   = moved_flag;
    shake_next        = 1'b0;
    moved_next        = 1'b0;

    case (req.kind)
      acd_pkg::KIND_POLL: begin
        moved_next      = moved_flag;
        moved_flag_next = 1'b0;
      end
      acd_pkg::KIND_SAMPLE: begin
        if (req.moved_hit) moved_flag_next = 1'b1;
        if (jolt) jolt_count_next = cnt_inc;
        if (jolt && (cnt_inc >= cfg.jolts_needed) && win_open) begin
          jolt_count_next   = '0;
          cooldown_end_next = req.now_ms +
                              {{(acd_pkg::TS_W-acd_pkg::MS_W){1'b0}}, cfg.cooldown_ms};
          shake_next        = 1'b1;
        end else if (win_over) begin
          // window ran out: drop the partial burst
          jolt_count_next = '0;
        end
      end
      default: begin
        moved_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jolt_count   <= '0;
      window_begin <= '0;
      cooldown_end <= acd_pkg::RST_COOLDOWN_END;
      moved_flag   <= 1'b0;
    end else if (pop) begin
      jolt_count   <= jolt_count_next;
      window_begin <= window_begin_next;
      cooldown_end <= cooldown_end_next;
      moved_flag   <= moved_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      shake <= shake_next;
      moved <= moved_next;
    end
  end

`ifndef NO_ASSERTIONS
  // a result never reports shake and moved together
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(shake && moved))
    else $error("shake and moved both set");

  // a shake restarts the jolt count
  a_shake_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && shake_next) |=> (jolt_count == '0))
    else $error("jolt count not cleared after shake");

  // a poll leaves the moved flag cleared
  a_poll_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && (req.kind == acd_pkg::KIND_POLL)) |=> !moved_flag)
    else $error("moved flag not cleared by poll");

  // a result waiting on the consumer blocks the queue
  a_no_pop_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !pop)
    else $error("queue popped while result stalled");
`endif

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Testbench for accel_shake_detector: directed and random sample/poll requests,
// each result checked against a local model of the jolt, window, cooldown and moved logic.
// Depends on acd_pkg and the accel_shake_detector RTL.
module tb;

  localparam int STALL_LIMIT = 2000;
  // Indexes past the last register; writes there must be ignored
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    acd_pkg::kind_t                   kind;
    logic signed [acd_pkg::ACC_W-1:0] ax;
    logic signed [acd_pkg::ACC_W-1:0] ay;
    logic signed [acd_pkg::ACC_W-1:0] az;
    logic [acd_pkg::TS_W-1:0]         ts;
  } accel_req_t;

  typedef struct packed {
    logic shake;
    logic moved;
  } shake_result_t;

  // DUT ports
  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_wr_en = 1'b0;
  logic [2:0]                       cfg_index = '0;
  logic [acd_pkg::CFG_W-1:0]        cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             kind = 1'b0;
  logic signed [acd_pkg::ACC_W-1:0] accel_x = '0;
  logic signed [acd_pkg::ACC_W-1:0] accel_y = '0;
  logic signed [acd_pkg::ACC_W-1:0] accel_z = '0;
  logic [acd_pkg::TS_W-1:0]         now_ms = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             shake;
  logic                             moved;

  accel_shake_detector u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .accel_x   (accel_x),
    .accel_y   (accel_y),
    .accel_z   (accel_z),
    .now_ms    (now_ms),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .shake     (shake),
    .moved     (moved)
  );

  // Model copy of the configuration registers
  logic [acd_pkg::MG_W-1:0]  thr_mg   = acd_pkg::RST_JOLT_THRESHOLD;
  logic [acd_pkg::CNT_W-1:0] need_cnt = acd_pkg::RST_JOLTS_NEEDED;
  logic [acd_pkg::MS_W-1:0]  win_ms   = acd_pkg::RST_WINDOW;
  logic [acd_pkg::MS_W-1:0]  cool_ms  = acd_pkg::RST_COOLDOWN;
  logic [acd_pkg::MG_W-1:0]  grav_mg  = acd_pkg::RST_GRAVITY;
  logic [acd_pkg::MG_W-1:0]  dev_mg   = acd_pkg::RST_WAKE_DEVIATION;

  // Model copy of the detector state
  logic [acd_pkg::CNT_W-1:0] jolts_seen   = '0;
  logic [acd_pkg::TS_W-1:0]  burst_start  = '0;
  logic [acd_pkg::TS_W-1:0]  holdoff_end  = acd_pkg::RST_COOLDOWN_END;
  logic                      moved_seen   = 1'b0;

  accel_req_t    pending_requests[$];
  shake_result_t expected_results[$];
  accel_req_t    drv_req;
  shake_result_t want;
  logic [acd_pkg::TS_W-1:0] ts_cursor = '0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  idle_cycles = 0;
  int  mismatch_cnt = 0;
  int  result_idx = 0;
  bit  steady = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Signed modular distance in ms from past to now
  function automatic int ms_since(logic [acd_pkg::TS_W-1:0] now,
                                  logic [acd_pkg::TS_W-1:0] past);
    logic [acd_pkg::TS_W-1:0] d;
    d = now - past;
    return signed'(d);
  endfunction

  function automatic logic signed [acd_pkg::ACC_W-1:0] to_axis(int v);
    int c;
    c = v;
    if (c > 8191) c = 8191;
    if (c < -8192) c = -8192;
    return c[acd_pkg::ACC_W-1:0];
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("mismatch: %s", msg);
  endtask

  // Expected result of one accepted request; updates the model state
  task automatic predict_shake(input accel_req_t r);
    shake_result_t res;
    longint ax, ay, az, m2, hi, lo, th;
    res = '0;
    if (r.kind == acd_pkg::KIND_POLL) begin
      res.moved = moved_seen;
      moved_seen = 1'b0;
    end else begin
      ax = r.ax;
      ay = r.ay;
      az = r.az;
      m2 = ax * ax + ay * ay + az * az;
      hi = longint'(grav_mg) + longint'(dev_mg);
      th = longint'(thr_mg);
      // moved: outside the band around gravity
      if (m2 > hi * hi) begin
        moved_seen = 1'b1;
      end else if (grav_mg > dev_mg) begin
        lo = longint'(grav_mg) - longint'(dev_mg);
        if (m2 < lo * lo) moved_seen = 1'b1;
      end
      // jolt counting outside the cooldown
      if (m2 > th * th && ms_since(r.ts, holdoff_end) > 0) begin
        if (jolts_seen == '0) burst_start = r.ts;
        if (jolts_seen < acd_pkg::CNT_MAX) jolts_seen = jolts_seen + 1'b1;
        if (jolts_seen >= need_cnt && ms_since(r.ts, burst_start) < int'(win_ms)) begin
          jolts_seen  = '0;
          holdoff_end = r.ts + acd_pkg::TS_W'(cool_ms);
          res.shake   = 1'b1;
        end
      end
      // stale burst
      if (jolts_seen != '0 && ms_since(r.ts, burst_start) > int'(win_ms)) jolts_seen = '0;
    end
    expected_results.push_back(res);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [acd_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      acd_pkg::REG_JOLT_THRESHOLD: thr_mg   = data[acd_pkg::MG_W-1:0];
      acd_pkg::REG_JOLTS_NEEDED:   need_cnt = data[acd_pkg::CNT_W-1:0];
      acd_pkg::REG_WINDOW:         win_ms   = data[acd_pkg::MS_W-1:0];
      acd_pkg::REG_COOLDOWN:       cool_ms  = data[acd_pkg::MS_W-1:0];
      acd_pkg::REG_GRAVITY:        grav_mg  = data[acd_pkg::MG_W-1:0];
      acd_pkg::REG_WAKE_DEVIATION: dev_mg   = data[acd_pkg::MG_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // All six registers, junk above the narrower field widths, plus one ignored index
  task automatic apply_config(input int thr, input int need, input int win, input int cool,
                              input int grav, input int dev);
    logic [acd_pkg::CFG_W-1:0] d;
    d = acd_pkg::CFG_W'($urandom); d[acd_pkg::MG_W-1:0] = thr[acd_pkg::MG_W-1:0];
    write_reg(acd_pkg::REG_JOLT_THRESHOLD, d);
    d = acd_pkg::CFG_W'($urandom); d[acd_pkg::CNT_W-1:0] = need[acd_pkg::CNT_W-1:0];
    write_reg(acd_pkg::REG_JOLTS_NEEDED, d);
    write_reg(acd_pkg::REG_WINDOW, win[acd_pkg::MS_W-1:0]);
    write_reg(acd_pkg::REG_COOLDOWN, cool[acd_pkg::MS_W-1:0]);
    d = acd_pkg::CFG_W'($urandom); d[acd_pkg::MG_W-1:0] = grav[acd_pkg::MG_W-1:0];
    write_reg(acd_pkg::REG_GRAVITY, d);
    d = acd_pkg::CFG_W'($urandom); d[acd_pkg::MG_W-1:0] = dev[acd_pkg::MG_W-1:0];
    write_reg(acd_pkg::REG_WAKE_DEVIATION, d);
    write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
              acd_pkg::CFG_W'($urandom));
  endtask

  task automatic push_item(input acd_pkg::kind_t k, input int x, input int y, input int z,
                           input logic [acd_pkg::TS_W-1:0] t);
    accel_req_t r;
    r.kind = k;
    r.ax   = to_axis(x);
    r.ay   = to_axis(y);
    r.az   = to_axis(z);
    r.ts   = t;
    pending_requests.push_back(r);
  endtask

  // One random request: mostly a plausible stream with jolts and quiet samples
  task automatic push_random(input int jolt_pct, input int hold_pct);
    int a[3];
    int pick, axis;
    acd_pkg::kind_t k;
    k = ($urandom_range(0, 9) == 0) ? acd_pkg::KIND_POLL : acd_pkg::KIND_SAMPLE;
    if ($urandom_range(0, 99) >= hold_pct) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) ts_cursor += $urandom_range(1, 60);
      else if (pick < 85) ts_cursor += $urandom_range(61, 3000);
      else if (pick < 92) ts_cursor = $urandom;
      else ts_cursor -= $urandom_range(1, 200);
    end
    axis = $urandom_range(0, 2);
    foreach (a[i]) a[i] = $urandom_range(0, 600) - 300;
    pick = $urandom_range(0, 99);
    if (pick < jolt_pct) begin
      a[axis] = int'(thr_mg) + $urandom_range(1, 3000);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // near the edges of the gravity band
        a[axis] = int'(grav_mg) - int'(dev_mg) - 60 + $urandom_range(0, 2 * dev_mg + 120);
      end else if (pick < 85) begin
        foreach (a[i]) a[i] = $urandom_range(0, 16383) - 8192;
      end else begin
        foreach (a[i]) begin
          case ($urandom_range(0, 4))
            0: a[i] = -8192;
            1: a[i] = 8191;
            2: a[i] = 0;
            3: a[i] = -1;
            default: a[i] = 1;
          endcase
        end
      end
    end
    if ($urandom_range(0, 1)) a[axis] = -a[axis];
    push_item(k, a[0], a[1], a[2], ts_cursor);
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_shake(drv_req);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          drv_req = pending_requests.pop_front();
          kind     <= drv_req.kind;
          accel_x  <= drv_req.ax;
          accel_y  <= drv_req.ay;
          accel_z  <= drv_req.az;
          now_ms   <= drv_req.ts;
          in_valid <= 1'b1;
          if (!steady && $urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("result %0d with nothing expected: shake=%0b moved=%0b",
                                  result_idx, shake, moved));
        end else begin
          want = expected_results.pop_front();
          if (shake !== want.shake)
            note_mismatch($sformatf("result %0d shake: expected %0b, got %0b",
                                    result_idx, want.shake, shake));
          if (moved !== want.moved)
            note_mismatch($sformatf("result %0d moved: expected %0b, got %0b",
                                    result_idx, want.moved, moved));
        end
        result_idx++;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!steady && $urandom_range(0, 15) == 0) recv_gap = $urandom_range(1, 19);
      end
    end
  end

  // Watchdog: too long without any accepted request or result
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    int items, jolt_pct, hold_pct;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, reset configuration
    push_item(acd_pkg::KIND_POLL,   0, 0, 0, 32'd0);          // flag clear after reset
    push_item(acd_pkg::KIND_SAMPLE, 0, 0, 0, 32'd100);        // below the gravity band
    push_item(acd_pkg::KIND_POLL,   0, 0, 0, 32'd100);
    push_item(acd_pkg::KIND_POLL,   0, 0, 0, 32'd100);        // cleared by the previous poll
    push_item(acd_pkg::KIND_SAMPLE, 1450, 0, 0, 32'd120);     // exactly on the upper band edge
    push_item(acd_pkg::KIND_SAMPLE, 550, 0, 0, 32'd140);      // exactly on the lower band edge
    push_item(acd_pkg::KIND_SAMPLE, 0, 1451, 0, 32'd160);     // just above the band
    push_item(acd_pkg::KIND_POLL,   0, 0, 0, 32'd160);
    push_item(acd_pkg::KIND_SAMPLE, 8191, 8191, 8191, 32'd1000);     // startup holdoff
    push_item(acd_pkg::KIND_SAMPLE, -8192, -8192, -8192, 32'd1500);  // holdoff end itself
    push_item(acd_pkg::KIND_SAMPLE, 1801, 0, 0, 32'd1501);    // first jolt
    push_item(acd_pkg::KIND_SAMPLE, 0, -1800, 0, 32'd1550);   // at threshold, not a jolt
    push_item(acd_pkg::KIND_SAMPLE, 0, 0, -8192, 32'd1600);
    push_item(acd_pkg::KIND_SAMPLE, 2000, 2000, 0, 32'd1700); // third jolt: shake
    push_item(acd_pkg::KIND_SAMPLE, 8191, 0, 0, 32'd2000);    // in cooldown
    push_item(acd_pkg::KIND_SAMPLE, 8191, 0, 0, 32'd3200);    // cooldown end itself
    push_item(acd_pkg::KIND_SAMPLE, 8191, 0, 0, 32'd3300);
    push_item(acd_pkg::KIND_SAMPLE, 8191, 0, 0, 32'd4101);    // outside the window, count cleared
    push_item(acd_pkg::KIND_SAMPLE, 8191, 0, 0, 32'd5000);
    push_item(acd_pkg::KIND_SAMPLE, 0, 0, 1000, 32'd5800);    // window edge, still kept
    push_item(acd_pkg::KIND_SAMPLE, 8191, 0, 0, 32'd5800);    // window edge, no shake
    push_item(acd_pkg::KIND_SAMPLE, 0, 0, 1000, 32'd5801);    // expiry on a quiet sample
    push_item(acd_pkg::KIND_SAMPLE, 8191, 0, 0, 32'd6000);
    push_item(acd_pkg::KIND_SAMPLE, 8191, 0, 0, 32'd6100);
    push_item(acd_pkg::KIND_SAMPLE, 8191, 0, 0, 32'd5900);    // time going back counts as open
    push_item(acd_pkg::KIND_POLL,   0, 0, 0, 32'd5900);
    ts_cursor = 32'd5900;

    for (int ph = 0; ph < 10; ph++) begin
      jolt_pct = 40;
      hold_pct = 15;
      items    = 150;
      if (ph > 0) begin
        wait_idle();
        case (ph)
          1: apply_config(0, 1, 0, 0, 0, 0);
          2: apply_config(16383, 15, 65535, 65535, 16383, 16383);
          3: apply_config(1200, 0, 300, 100, 1000, 200);   // zero jolts needed
          4: begin                                         // saturating count
            apply_config(100, 15, 0, 0, 1000, 450);
            jolt_pct = 85;
            hold_pct = 85;
          end
          5: begin                                         // timestamp wrap
            apply_config(1800, 3, 800, 1500, 1000, 450);
            ts_cursor = 32'hFFFF_F000;
          end
          9: begin
            apply_config(1800, 3, 800, 1500, 1000, 450);
            steady = 1'b1;
            items  = 180;
          end
          default: apply_config($urandom_range(300, 3000), $urandom_range(0, 15),
                                $urandom_range(0, 2000), $urandom_range(0, 3000),
                                $urandom_range(700, 1300), $urandom_range(0, 700));
        endcase
        // squared thresholds settle in the cycle after the write
        repeat (3) @(posedge clk);
        @(negedge clk);
      end
      for (int n = 0; n < items; n++) begin
        push_random(jolt_pct, hold_pct);
        if (n % 50 == 49) begin
          while (pending_requests.size() != 0) @(negedge clk);
          if (n == 99) wait_idle();  // hold off until the pipe has drained
        end
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/acd_pkg.sv
rtl/acd_front.sv
rtl/acd_fifo.sv
rtl/acd_back.sv
rtl/accel_shake_detector.sv
verif/tb.sv
